// ----- design/mswb_pkg.sv -----
`default_nettype none

package mswb_pkg;

    // maze size
    localparam int ROWS = 16;
    localparam int COLS = 16;

    // cell index widths
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;

    // one vertical-wall row holds COLS+1 bits, one horizontal-wall column ROWS+1 bits
    localparam int VROW_W = COLS + 1;
    localparam int HCOL_W = ROWS + 1;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // command codes on the input stream
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_CLEAR
    } op_t;

    // classified request
    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [ROW_AW-1:0] row;
        logic [COL_AW-1:0] col;
        logic              west;
        logic              north;
        logic              east;
        logic              south;
    } item_t;

    typedef struct packed {
        logic in_range;
        logic west;
        logic north;
        logic east;
        logic south;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

endpackage

`default_nettype wire

// ----- design/mswb_front.sv -----
`default_nettype none

module mswb_front (
    input  wire logic [1:0]    cmd,
    input  wire logic [7:0]    row,
    input  wire logic [7:0]    col,
    input  wire logic          west_in,
    input  wire logic          north_in,
    input  wire logic          east_in,
    input  wire logic          south_in,
    output mswb_pkg::item_t    item
);
    import mswb_pkg::*;

    localparam logic [7:0] ROWS_B = 8'(ROWS);
    localparam logic [7:0] COLS_B = 8'(COLS);

    logic in_range;
    op_t  op;

    assign in_range = (row < ROWS_B) && (col < COLS_B);

    always_comb
    begin
        case (cmd)
            CMD_WRITE: op = OP_WRITE;
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ:  op = OP_READ;
            default:   op = OP_READ;  // unused code behaves as a read
        endcase
    end

    always_comb
    begin
        item.op       = op;
        item.in_range = in_range;
        // out-of-range cells get a harmless index, the back ignores them anyway
        item.row      = in_range ? row[ROW_AW-1:0] : '0;
        item.col      = in_range ? col[COL_AW-1:0] : '0;
        item.west     = west_in;
        item.north    = north_in;
        item.east     = east_in;
        item.south    = south_in;
    end

endmodule

`default_nettype wire

// ----- design/mswb_queue.sv -----
`default_nettype none

module mswb_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire mswb_pkg::item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output mswb_pkg::item_t      pop_item
);
    import mswb_pkg::*;

    item_t            entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != QCW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/mswb_back.sv -----
`default_nettype none

module mswb_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire mswb_pkg::item_t q_item,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output mswb_pkg::result_t    res
);
    import mswb_pkg::*;

    bk_state_t          state_reg, state_next;
    item_t              item_reg;

    // wall stores: vertical walls by row, horizontal walls by column
    logic [VROW_W-1:0]  vmem_reg [ROWS];
    logic [HCOL_W-1:0]  hmem_reg [COLS];
    logic [ROWS-1:0]    vvalid_reg;
    logic [COLS-1:0]    hvalid_reg;

    // registered read port
    logic [VROW_W-1:0]  vrd_reg;
    logic [HCOL_W-1:0]  hrd_reg;
    logic               vok_reg, hok_reg;

    logic               out_valid_reg, out_valid_next;
    result_t            res_reg;

    logic               rd_en, fire, wr_en, clr_en;
    logic [VROW_W-1:0]  cur_v, v_shift, v_mask, v_wdata;
    logic [HCOL_W-1:0]  cur_h, h_shift, h_mask, h_wdata;
    result_t            res_new;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_ready = 1'b0;
        rd_en   = 1'b0;
        fire    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                rd_en   = q_valid;
            end
            BK_EXEC:
            begin
                fire = !out_valid_reg || res_ready;
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    // merge the four addressed bits into the rows that were read
    always_comb
    begin
        cur_v   = vok_reg ? vrd_reg : '0;
        cur_h   = hok_reg ? hrd_reg : '0;
        v_shift = cur_v >> item_reg.col;
        h_shift = cur_h >> item_reg.row;
        v_mask  = VROW_W'(2'b11) << item_reg.col;
        h_mask  = HCOL_W'(2'b11) << item_reg.row;
        v_wdata = (cur_v & ~v_mask)
                | (VROW_W'({item_reg.east, item_reg.west}) << item_reg.col);
        h_wdata = (cur_h & ~h_mask)
                | (HCOL_W'({item_reg.south, item_reg.north}) << item_reg.row);
        wr_en   = fire && (item_reg.op == OP_WRITE) && item_reg.in_range;
        clr_en  = fire && (item_reg.op == OP_CLEAR);

        res_new.in_range = item_reg.in_range;
        res_new.west     = 1'b0;
        res_new.north    = 1'b0;
        res_new.east     = 1'b0;
        res_new.south    = 1'b0;
        if (item_reg.in_range)
        begin
            case (item_reg.op)
                OP_WRITE:
                begin
                    res_new.west  = item_reg.west;
                    res_new.north = item_reg.north;
                    res_new.east  = item_reg.east;
                    res_new.south = item_reg.south;
                end
                OP_READ:
                begin
                    res_new.west  = v_shift[0];
                    res_new.east  = v_shift[1];
                    res_new.north = h_shift[0];
                    res_new.south = h_shift[1];
                end
                default:
                begin
                    res_new.west = 1'b0;  // clear leaves every wall open
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            vvalid_reg    <= '0;
            hvalid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clr_en)
            begin
                vvalid_reg <= '0;
                hvalid_reg <= '0;
            end
            else if (wr_en)
            begin
                vvalid_reg[item_reg.row] <= 1'b1;
                hvalid_reg[item_reg.col] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            item_reg <= q_item;
            vrd_reg  <= vmem_reg[q_item.row];
            hrd_reg  <= hmem_reg[q_item.col];
            vok_reg  <= vvalid_reg[q_item.row];
            hok_reg  <= hvalid_reg[q_item.col];
        end
        if (wr_en)
        begin
            vmem_reg[item_reg.row] <= v_wdata;
            hmem_reg[item_reg.col] <= h_wdata;
        end
        if (fire)
        begin
            res_reg <= res_new;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- design/maze_shared_wall_bitmap.sv -----
// Maze wall map: keeps the walls of a ROWS x COLS maze (16 x 16 as built) at one bit per
// wall, so two neighboring cells always see the same shared wall. Each request on the input
// stream reads a cell's four walls, writes them, or clears the whole map, and every request
// returns exactly one result on the output stream with the cell's walls after the command
// plus an in-range flag; a cell outside the maze reports all walls open, a write to it
// changes nothing, and a clear still reports in_range for the cell given. Requests are
// classified in a front stage, wait in a two-entry queue, and are carried out by a back
// stage that does a registered read of the cell's vertical-wall row and horizontal-wall
// column, then a merge and write back; the back takes a new request from the queue only
// after the previous one has executed, and the result is registered after the merge and
// held on the output stream until it is taken. The map is empty after reset with no
// clearing pass: per-row and per-column valid flops mark what was written, and a clear
// drops them all. Unused command code 3 acts as a read.

`default_nettype none

module maze_shared_wall_bitmap (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // row[7:0], col[15:8], west_in, north_in,
                                             // east_in, south_in, zero pad[23:20]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // in_range, west_out, north_out, east_out,
                                             // south_out, zero pad[7:5]
);
    import mswb_pkg::*;

    item_t   front_item;
    item_t   q_item;
    logic    q_valid, q_ready;
    result_t res;

    // front: range check and command decode
    mswb_front u_front (
        .cmd      (s_axis_tuser),
        .row      (s_axis_tdata[7:0]),
        .col      (s_axis_tdata[15:8]),
        .west_in  (s_axis_tdata[16]),
        .north_in (s_axis_tdata[17]),
        .east_in  (s_axis_tdata[18]),
        .south_in (s_axis_tdata[19]),
        .item     (front_item)
    );

    // queue decouples acceptance from execution
    mswb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // back: wall store access and result register
    mswb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {3'b000, res.south, res.east, res.north, res.west, res.in_range};

endmodule

`default_nettype wire

// ----- design/mswb_checker.sv -----
`default_nettype none

module mswb_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an out-of-range cell never reports a wall
    a_oor_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'b0000)
        else $error("out-of-range cell shows walls");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("result pad bits set");

endmodule

bind maze_shared_wall_bitmap mswb_checker u_mswb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
